/* rtl/core/ust_pkg.sv */
// Package for the unordered set table: command codes and control states.
// No dependencies; used by the table core.
package ust_pkg;

	// Command codes carried by each input transfer.
	typedef enum logic [1:0] {
		CMD_LOOKUP = 2'd0,
		CMD_INSERT = 2'd1,
		CMD_DELETE = 2'd2,
		CMD_UNUSED = 2'd3
	} cmd_t;

	// Width of the capacity register and of the reported index and count.
	localparam int CAP_W   = 7;
	localparam int COUNT_W = 7;
	localparam int VALUE_W = 32;

	// Control states of the table sequencer.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_APPLY,
		ST_SHIFT,
		ST_RESP
	} state_t;

endpackage

/* rtl/core/ust_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module ust_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port; read data is registered.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/core/unordered_set_table.sv */
// Unordered set table: insertion-ordered table of 32-bit values in one RAM,
// searched linearly, compacted after delete. Depends on ust_pkg and ust_ram.
//
//   channel   dir   handshake           payload
//   in        in    in_valid/in_ready   cmd, item_value
//   out       out   out_valid/out_ready found, match_index, entry_count, full_refused
//   cfg       in    cfg_we              cfg_wdata (capacity_limit)
//
// One item at a time. The search streams one RAM read per cycle and compares
// each result in the next cycle. A delete that hits searches up to the match,
// then does one read and one write-back per later entry through the same RAM.
// Reset clears the count and sets the capacity to 64; the RAM is not cleared.
// A result that is not taken holds the sequencer in its response state.
module unordered_set_table #(
	parameter int TABLE_DEPTH = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [1:0]                  cmd,
	input  logic signed [31:0]          item_value,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        found,
	output logic [6:0]                  match_index,
	output logic [6:0]                  entry_count,
	output logic                        full_refused,
	input  logic                        cfg_we,
	input  logic [6:0]                  cfg_wdata
);

	localparam int AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int CMP_W = (CNT_W > ust_pkg::CAP_W) ? CNT_W : ust_pkg::CAP_W;

	ust_pkg::state_t state_q, state_d;

	logic [ust_pkg::CAP_W-1:0]   cap_q;
	logic [CNT_W-1:0]            count_q;
	logic [CNT_W-1:0]            ptr_q;
	logic [CNT_W-1:0]            idx_q;
	logic                        hit_q;
	logic                        refused_q;
	ust_pkg::cmd_t               cmd_q;
	logic [ust_pkg::VALUE_W-1:0] value_q;
	logic                        rd_vld_s1;
	logic [CNT_W-1:0]            rd_idx_s1;
	logic                        out_valid_q;

	logic                        issue_rd;
	logic                        hit_now;
	logic                        load_item;
	logic                        search_end;
	logic                        do_insert;
	logic                        do_refuse;
	logic                        start_shift;
	logic                        shift_end;
	logic                        load_out;
	logic [CMP_W-1:0]            eff_cap;
	logic [CNT_W-1:0]            shift_dst;

	logic                        ram_we;
	logic [AW-1:0]               ram_waddr;
	logic [ust_pkg::VALUE_W-1:0] ram_wdata;
	logic [ust_pkg::VALUE_W-1:0] ram_rdata;

	// Capacity register; a limit above the depth acts as the depth.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= ust_pkg::CAP_W'(64);
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	assign eff_cap = (CMP_W'(cap_q) > CMP_W'(TABLE_DEPTH)) ? CMP_W'(TABLE_DEPTH)
	                                                       : CMP_W'(cap_q);

	assign hit_now   = rd_vld_s1 && (ram_rdata == value_q);
	assign shift_dst = rd_idx_s1 - CNT_W'(1);

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ust_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and control strobes.
	always_comb begin
		state_d     = state_q;
		in_ready    = 1'b0;
		issue_rd    = 1'b0;
		load_item   = 1'b0;
		search_end  = 1'b0;
		do_insert   = 1'b0;
		do_refuse   = 1'b0;
		start_shift = 1'b0;
		shift_end   = 1'b0;
		load_out    = 1'b0;
		case (state_q)
			ust_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					load_item = 1'b1;
					state_d   = ust_pkg::ST_SEARCH;
				end
			end
			ust_pkg::ST_SEARCH: begin
				issue_rd = !hit_now && (ptr_q < count_q);
				if (hit_now || (!rd_vld_s1 && (ptr_q >= count_q))) begin
					search_end = 1'b1;
					state_d    = ust_pkg::ST_APPLY;
				end
			end
			ust_pkg::ST_APPLY: begin
				state_d = ust_pkg::ST_RESP;
				if (cmd_q == ust_pkg::CMD_INSERT) begin
					if (CMP_W'(count_q) < eff_cap) begin
						do_insert = 1'b1;
					end else begin
						do_refuse = 1'b1;
					end
				end else if ((cmd_q == ust_pkg::CMD_DELETE) && hit_q) begin
					start_shift = 1'b1;
					state_d     = ust_pkg::ST_SHIFT;
				end
			end
			ust_pkg::ST_SHIFT: begin
				issue_rd = (ptr_q < count_q);
				if (!issue_rd && !rd_vld_s1) begin
					shift_end = 1'b1;
					state_d   = ust_pkg::ST_RESP;
				end
			end
			ust_pkg::ST_RESP: begin
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_d  = ust_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ust_pkg::ST_IDLE;
			end
		endcase
	end

	// Read pipeline and control counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
			count_q   <= '0;
		end else begin
			rd_vld_s1 <= issue_rd;
			if (do_insert) begin
				count_q <= count_q + CNT_W'(1);
			end else if (shift_end) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	// Working registers of the item in flight.
	always_ff @(posedge clk) begin
		if (issue_rd) begin
			rd_idx_s1 <= ptr_q;
		end
		if (load_item) begin
			cmd_q     <= ust_pkg::cmd_t'(cmd);
			value_q   <= item_value;
			ptr_q     <= '0;
			refused_q <= 1'b0;
		end else if (start_shift) begin
			ptr_q <= idx_q + CNT_W'(1);
		end else if (issue_rd) begin
			ptr_q <= ptr_q + CNT_W'(1);
		end
		if (search_end) begin
			hit_q <= hit_now;
			idx_q <= hit_now ? rd_idx_s1 : count_q;
		end
		if (do_refuse) begin
			refused_q <= 1'b1;
		end
	end

	// Output register; a waiting result holds until its transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			found        <= hit_q;
			match_index  <= ust_pkg::COUNT_W'(idx_q);
			entry_count  <= ust_pkg::COUNT_W'(count_q);
			full_refused <= refused_q;
		end
	end

	assign out_valid = out_valid_q;

	// RAM write: append on insert, move an entry down one place while shifting.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = count_q[AW-1:0];
		ram_wdata = value_q;
		if (do_insert) begin
			ram_we = 1'b1;
		end else if ((state_q == ust_pkg::ST_SHIFT) && rd_vld_s1) begin
			ram_we    = 1'b1;
			ram_waddr = shift_dst[AW-1:0];
			ram_wdata = ram_rdata;
		end
	end

	ust_ram #(
		.WIDTH(ust_pkg::VALUE_W),
		.DEPTH(TABLE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (issue_rd),
		.raddr (ptr_q[AW-1:0]),
		.rdata (ram_rdata)
	);

endmodule

/* rtl/core/ust_checker.sv */
// Port-level checker for the unordered set table, bound to the top level.
// Depends on unordered_set_table being compiled first.
module ust_checker #(
	parameter int TABLE_DEPTH = 64
) (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic        found,
	input logic [6:0]  match_index,
	input logic [6:0]  entry_count,
	input logic        full_refused
);

	// A result that waits keeps its fields.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(found) && $stable(match_index)
			&& $stable(entry_count) && $stable(full_refused))
		else $error("waiting result changed");

	// An accepted item closes the input until its work is done.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second item taken while one is in flight");

	// A new result only appears while the input is closed.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared without an item in flight");

	// The first match never lies beyond the count after the operation.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (TABLE_DEPTH > 127) || (match_index <= entry_count))
		else $error("match index beyond entry count");

endmodule

bind unordered_set_table ust_checker #(
	.TABLE_DEPTH(TABLE_DEPTH)
) u_ust_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.found        (found),
	.match_index  (match_index),
	.entry_count  (entry_count),
	.full_refused (full_refused)
);
